[hdl/pllm_pkg.sv]
// Package for the pooled linked list manager: beat structs, op codes, pool sizes.
// No dependencies.
`default_nettype none
package pllm_pkg;
   localparam int NodeCountDef = 256;
   localparam int HeadCountDef = 16;
   localparam int ItemWidthDef = 32;

   typedef enum logic [3:0] {
      OP_CREATE  = 4'd0,
      OP_COUNT   = 4'd1,
      OP_FIRST   = 4'd2,
      OP_LAST    = 4'd3,
      OP_NEXT    = 4'd4,
      OP_PREV    = 4'd5,
      OP_CURR    = 4'd6,
      OP_ADD     = 4'd7,
      OP_INSERT  = 4'd8,
      OP_APPEND  = 4'd9,
      OP_PREPEND = 4'd10,
      OP_REMOVE  = 4'd11,
      OP_TRIM    = 4'd12,
      OP_CONCAT  = 4'd13,
      OP_FREE    = 4'd14,
      OP_NONE    = 4'd15
   } op_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [3:0]  list_id;
      logic [3:0]  other_list;
      logic [31:0] item;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] item_out;
      logic [3:0]  new_handle;
      logic [8:0]  length_out;
   } rsp_type;
endpackage
`default_nettype wire

[hdl/pllm_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pllm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/pooled_linked_list_manager.sv]
// Pooled linked list manager. RAM reads are registered; a free op walks the list
// node by node from the head, handing each node back to the free-node stack.
// One beat in flight; req_ready is high only in S_IDLE, which is entered as the result
// moves to the rsp register, where it may wait while the next beat is worked on.
// Reset: synchronous; clears head tables at once, then sweeps the free-node
// stack with i at entry i before the first req beat.
`default_nettype none
module pooled_linked_list_manager #(
   parameter int NodeCount = pllm_pkg::NodeCountDef,
   parameter int HeadCount = pllm_pkg::HeadCountDef,
   parameter int ItemWidth = pllm_pkg::ItemWidthDef
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pllm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pllm_pkg::rsp_type     rsp_data
);
   localparam int NW = $clog2(NodeCount);   // node index bits
   localparam int PW = NW + 1;              // pointer bits, NodeCount is null
   localparam int HW = (HeadCount > 1) ? $clog2(HeadCount) : 1;
   localparam int CW = $clog2(HeadCount + 1);
   localparam int LW = 9;
   localparam logic [PW-1:0] NIL = PW'(NodeCount);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DEC, S_RD1, S_RD2, S_WR1, S_WR2, S_WR3,
      S_FREE_RD, S_FREE_WT, S_FREE_GO, S_DONE
   } state_type;

   // head tables (small, read at the op's handle and, for concat, the other handle: flops)
   logic [PW-1:0] head_ff [HeadCount];
   logic [PW-1:0] tail_ff [HeadCount];
   logic [PW-1:0] cur_ff  [HeadCount];
   logic          bef_ff  [HeadCount];
   logic          aft_ff  [HeadCount];
   logic [LW-1:0] len_ff  [HeadCount];
   logic          live_ff [HeadCount];
   logic [HW-1:0] fhs_ff  [HeadCount];
   logic [CW-1:0] hused_ff;
   logic [PW-1:0] nused_ff;

   state_type     state_ff;
   pllm_pkg::req_type req_ff;
   logic          rsp_valid_ff;
   pllm_pkg::rsp_type rsp_ff;
   pllm_pkg::rsp_type res_ff;   // result being built for the beat in work
   logic [NW-1:0] sweep_ff;

   // node memories and free-node stack
   logic              nw_we, nf_we, nb_we, fs_we;
   logic [NW-1:0]     nw_wa, nf_wa, nb_wa, fs_wa;
   logic [ItemWidth-1:0] nw_wd, nw_rd;
   logic [PW-1:0]     nf_wd, nb_wd, nf_rd, nb_rd;
   logic [NW-1:0]     nw_ra, nf_ra, nb_ra, fs_ra;
   logic [NW-1:0]     fs_wd, fs_rd;

   logic [NW-1:0]     ra_ff;    // node read address used by all node RAMs
   logic [NW-1:0]     fra_ff;   // free stack read address
   logic [PW-1:0]     n_ff;     // allocated or walked node
   logic [PW-1:0]     p_ff, q_ff;
   logic          step_ff;

   assign nw_ra = ra_ff;
   assign nf_ra = ra_ff;
   assign nb_ra = ra_ff;
   assign fs_ra = fra_ff;

   pllm_ram #(.Width(ItemWidth), .Depth(NodeCount)) u_word (
      .clock, .wr_en(nw_we), .wr_addr(nw_wa), .wr_data(nw_wd),
      .rd_addr(nw_ra), .rd_data(nw_rd));
   pllm_ram #(.Width(PW), .Depth(NodeCount)) u_fwd (
      .clock, .wr_en(nf_we), .wr_addr(nf_wa), .wr_data(nf_wd),
      .rd_addr(nf_ra), .rd_data(nf_rd));
   pllm_ram #(.Width(PW), .Depth(NodeCount)) u_bwd (
      .clock, .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_addr(nb_ra), .rd_data(nb_rd));
   pllm_ram #(.Width(NW), .Depth(NodeCount)) u_fstk (
      .clock, .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd));

   // current beat decode
   pllm_pkg::op_type op;
   logic [HW-1:0] h, o;
   logic          ok_h, ok_o;
   logic [PW-1:0] hh, ht, hc;
   logic          hb, ha, eff_after;
   logic [LW-1:0] hl;
   logic          is_ins;

   always_comb begin
      op   = pllm_pkg::op_type'(req_ff.kind);
      h    = HW'(req_ff.list_id);
      o    = HW'(req_ff.other_list);
      ok_h = (32'(req_ff.list_id) < HeadCount) && live_ff[h];
      ok_o = (32'(req_ff.other_list) < HeadCount) && live_ff[o];
      hh   = head_ff[h];
      ht   = tail_ff[h];
      hc   = cur_ff[h];
      hb   = bef_ff[h];
      ha   = aft_ff[h];
      hl   = len_ff[h];
      eff_after = ha || (hc == NIL && !hb);
      is_ins = (op == pllm_pkg::OP_ADD) || (op == pllm_pkg::OP_INSERT) ||
               (op == pllm_pkg::OP_APPEND) || (op == pllm_pkg::OP_PREPEND);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // node RAM write ports are driven from registered requests
   logic              nw_we_ff, nf_we_ff, nb_we_ff, fs_we_ff;
   logic [NW-1:0]     nw_wa_ff, nf_wa_ff, nb_wa_ff, fs_wa_ff;
   logic [ItemWidth-1:0] nw_wd_ff;
   logic [PW-1:0]     nf_wd_ff, nb_wd_ff;
   logic [NW-1:0]     fs_wd_ff;
   assign nw_we = nw_we_ff; assign nw_wa = nw_wa_ff; assign nw_wd = nw_wd_ff;
   assign nf_we = nf_we_ff; assign nf_wa = nf_wa_ff; assign nf_wd = nf_wd_ff;
   assign nb_we = nb_we_ff; assign nb_wa = nb_wa_ff; assign nb_wd = nb_wd_ff;
   assign fs_we = fs_we_ff; assign fs_wa = fs_wa_ff; assign fs_wd = fs_wd_ff;

   logic [NW-1:0] top_idx;   // NodeCount - nused, slot just past live ones
   assign top_idx = NW'(PW'(NodeCount) - nused_ff);

   always_ff @(posedge clock) begin
      nw_we_ff <= 1'b0;
      nf_we_ff <= 1'b0;
      nb_we_ff <= 1'b0;
      fs_we_ff <= 1'b0;
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hused_ff     <= '0;
         nused_ff     <= '0;
         for (int i = 0; i < HeadCount; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
            cur_ff[i]  <= NIL;
            bef_ff[i]  <= 1'b1;
            aft_ff[i]  <= 1'b0;
            len_ff[i]  <= '0;
            live_ff[i] <= 1'b0;
            fhs_ff[i]  <= HW'(i);
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               fs_we_ff <= 1'b1;
               fs_wa_ff <= sweep_ff;
               fs_wd_ff <= sweep_ff;
               sweep_ff <= sweep_ff + 1'b1;
               if (32'(sweep_ff) == NodeCount - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff   <= req_data;
                  fra_ff   <= '0;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               // default result: failure
               res_ff   <= '{status: 1'b1, item_out: '0, new_handle: '0, length_out: '0};
               state_ff <= S_DONE;
               step_ff  <= 1'b0;
               if (op == pllm_pkg::OP_CREATE) begin
                  if (32'(hused_ff) < HeadCount) begin
                     hused_ff <= hused_ff + 1'b1;
                     fhs_ff[0] <= fhs_ff[HW'(HeadCount - 1 - 32'(hused_ff))];
                     head_ff[fhs_ff[0]] <= NIL;
                     tail_ff[fhs_ff[0]] <= NIL;
                     cur_ff[fhs_ff[0]]  <= NIL;
                     bef_ff[fhs_ff[0]]  <= 1'b1;
                     aft_ff[fhs_ff[0]]  <= 1'b0;
                     len_ff[fhs_ff[0]]  <= '0;
                     live_ff[fhs_ff[0]] <= 1'b1;
                     res_ff.status     <= 1'b0;
                     res_ff.new_handle <= 4'(fhs_ff[0]);
                  end
               end else if (op != pllm_pkg::OP_NONE && ok_h) begin
                  res_ff.length_out <= hl;
                  case (op)
                     pllm_pkg::OP_COUNT: res_ff.status <= 1'b0;
                     pllm_pkg::OP_FIRST, pllm_pkg::OP_LAST: begin
                        if (hl != 0) begin
                           n_ff     <= (op == pllm_pkg::OP_FIRST) ? hh : ht;
                           cur_ff[h] <= (op == pllm_pkg::OP_FIRST) ? hh : ht;
                           bef_ff[h] <= 1'b0;
                           aft_ff[h] <= 1'b0;
                           ra_ff    <= NW'((op == pllm_pkg::OP_FIRST) ? hh : ht);
                           state_ff <= S_RD1;
                        end
                     end
                     pllm_pkg::OP_NEXT: begin
                        if (hl != 0) begin
                           if (hb) begin
                              cur_ff[h] <= hh;
                              bef_ff[h] <= 1'b0;
                              ra_ff <= NW'(hh);
                              state_ff <= S_RD1;
                           end else if (hc == ht || eff_after) begin
                              cur_ff[h] <= NIL;
                              aft_ff[h] <= 1'b1;
                           end else begin
                              ra_ff <= NW'(hc);
                              step_ff <= 1'b1;
                              state_ff <= S_RD1;
                           end
                        end
                     end
                     pllm_pkg::OP_PREV: begin
                        if (hl != 0) begin
                           if (eff_after) begin
                              cur_ff[h] <= ht;
                              aft_ff[h] <= 1'b0;
                              ra_ff <= NW'(ht);
                              state_ff <= S_RD1;
                           end else if (hc == hh || hb) begin
                              cur_ff[h] <= NIL;
                              bef_ff[h] <= 1'b1;
                           end else begin
                              ra_ff <= NW'(hc);
                              step_ff <= 1'b1;
                              state_ff <= S_RD1;
                           end
                        end
                     end
                     pllm_pkg::OP_CURR: begin
                        if (hl != 0 && hc != NIL) begin
                           ra_ff <= NW'(hc);
                           state_ff <= S_RD1;
                        end
                     end
                     pllm_pkg::OP_ADD, pllm_pkg::OP_INSERT,
                     pllm_pkg::OP_APPEND, pllm_pkg::OP_PREPEND: begin
                        if (req_ff.item != 0 && nused_ff < PW'(NodeCount)) begin
                           // free stack slot 0 is read this cycle
                           fra_ff <= top_idx - 1'b1;
                           ra_ff  <= NW'(hc);
                           state_ff <= S_RD1;
                        end
                     end
                     pllm_pkg::OP_REMOVE: begin
                        if (hc != NIL && hl != 0) begin
                           ra_ff <= NW'(hc);
                           n_ff  <= hc;
                           state_ff <= S_RD1;
                        end
                     end
                     pllm_pkg::OP_TRIM: begin
                        if (hl != 0) begin
                           ra_ff <= NW'(ht);
                           n_ff  <= ht;
                           state_ff <= S_RD1;
                        end
                     end
                     pllm_pkg::OP_CONCAT: begin
                        if (ok_o && o != h) begin
                           if (len_ff[o] != 0) begin
                              if (hl == 0) begin
                                 head_ff[h] <= head_ff[o];
                              end else begin
                                 nf_we_ff <= 1'b1;
                                 nf_wa_ff <= NW'(ht);
                                 nf_wd_ff <= head_ff[o];
                                 nb_we_ff <= 1'b1;
                                 nb_wa_ff <= NW'(head_ff[o]);
                                 nb_wd_ff <= ht;
                              end
                              tail_ff[h] <= tail_ff[o];
                              len_ff[h]  <= hl + len_ff[o];
                              res_ff.length_out <= hl + len_ff[o];
                           end
                           if (hused_ff != 0) begin
                              hused_ff <= hused_ff - 1'b1;
                              fhs_ff[HW'(HeadCount - 32'(hused_ff))] <= o;
                              head_ff[o] <= NIL;
                              tail_ff[o] <= NIL;
                              cur_ff[o]  <= NIL;
                              bef_ff[o]  <= 1'b1;
                              aft_ff[o]  <= 1'b0;
                              len_ff[o]  <= '0;
                              live_ff[o] <= 1'b0;
                           end
                           res_ff.status <= 1'b0;
                        end
                     end
                     pllm_pkg::OP_FREE: begin
                        n_ff     <= hh;
                        state_ff <= S_FREE_RD;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD1: state_ff <= S_RD2;   // node RAMs and free stack read
            S_RD2: begin
               state_ff <= S_DONE;
               case (op)
                  pllm_pkg::OP_FIRST, pllm_pkg::OP_LAST, pllm_pkg::OP_CURR: begin
                     res_ff.status   <= 1'b0;
                     res_ff.item_out <= 32'(nw_rd);
                  end
                  pllm_pkg::OP_NEXT, pllm_pkg::OP_PREV: begin
                     if (step_ff) begin
                        // moved one link; read the new node's word
                        cur_ff[h] <= (op == pllm_pkg::OP_NEXT) ? nf_rd : nb_rd;
                        ra_ff    <= NW'((op == pllm_pkg::OP_NEXT) ? nf_rd : nb_rd);
                        step_ff  <= 1'b0;
                        state_ff <= S_RD1;
                     end else begin
                        res_ff.status   <= 1'b0;
                        res_ff.item_out <= 32'(nw_rd);
                     end
                  end
                  pllm_pkg::OP_REMOVE, pllm_pkg::OP_TRIM: begin
                     res_ff.status   <= 1'b0;
                     res_ff.item_out <= 32'(nw_rd);
                     p_ff <= nb_rd;
                     q_ff <= nf_rd;
                     state_ff <= S_WR1;
                  end
                  default: begin
                     // insertion: fs_rd holds the new slot's refill; n from slot 0
                     if (is_ins) begin
                        fs_we_ff <= 1'b1;
                        fs_wa_ff <= '0;
                        fs_wd_ff <= fs_rd;
                        nused_ff <= nused_ff + 1'b1;
                        nw_we_ff <= 1'b1;
                        nw_wa_ff <= NW'(n_ff);
                        nw_wd_ff <= ItemWidth'(req_ff.item);
                        if (hl == 0) begin
                           p_ff <= NIL; q_ff <= NIL;
                        end else if (op == pllm_pkg::OP_PREPEND ||
                                     (op == pllm_pkg::OP_ADD && hb) ||
                                     (op == pllm_pkg::OP_INSERT && (hb || hc == hh))) begin
                           p_ff <= NIL; q_ff <= hh;
                        end else if (op == pllm_pkg::OP_APPEND || eff_after ||
                                     (op == pllm_pkg::OP_ADD && hc == ht)) begin
                           p_ff <= ht; q_ff <= NIL;
                        end else if (op == pllm_pkg::OP_ADD) begin
                           p_ff <= hc; q_ff <= nf_rd;
                        end else begin
                           p_ff <= nb_rd; q_ff <= hc;
                        end
                        state_ff <= S_WR1;
                     end
                  end
               endcase
            end
            S_WR1: begin
               state_ff <= S_WR2;
               if (is_ins) begin
                  nf_we_ff <= 1'b1; nf_wa_ff <= NW'(n_ff); nf_wd_ff <= q_ff;
                  nb_we_ff <= 1'b1; nb_wa_ff <= NW'(n_ff); nb_wd_ff <= p_ff;
               end else begin
                  // unlink: p.fwd = q, q.bwd = p
                  if (p_ff == NIL) head_ff[h] <= q_ff;
                  else begin
                     nf_we_ff <= 1'b1; nf_wa_ff <= NW'(p_ff); nf_wd_ff <= q_ff;
                  end
                  if (q_ff == NIL) tail_ff[h] <= p_ff;
                  else begin
                     nb_we_ff <= 1'b1; nb_wa_ff <= NW'(q_ff); nb_wd_ff <= p_ff;
                  end
                  if (nused_ff != 0) begin
                     fs_we_ff <= 1'b1; fs_wa_ff <= top_idx; fs_wd_ff <= NW'(n_ff);
                     nused_ff <= nused_ff - 1'b1;
                  end
                  len_ff[h] <= hl - 1'b1;
                  res_ff.length_out <= hl - 1'b1;
                  if (op == pllm_pkg::OP_REMOVE) begin
                     if (n_ff == ht) begin
                        cur_ff[h] <= NIL; aft_ff[h] <= 1'b1;
                     end else cur_ff[h] <= q_ff;
                  end else if (hl == 1) begin
                     head_ff[h] <= NIL; tail_ff[h] <= NIL;
                     cur_ff[h] <= NIL; bef_ff[h] <= 1'b1;
                  end else cur_ff[h] <= p_ff;
                  state_ff <= S_DONE;
               end
            end
            S_WR2: begin
               // link neighbors to the new node
               if (p_ff == NIL) head_ff[h] <= n_ff;
               else begin
                  nf_we_ff <= 1'b1; nf_wa_ff <= NW'(p_ff); nf_wd_ff <= n_ff;
               end
               if (q_ff == NIL) tail_ff[h] <= n_ff;
               else begin
                  nb_we_ff <= 1'b1; nb_wa_ff <= NW'(q_ff); nb_wd_ff <= n_ff;
               end
               len_ff[h] <= hl + 1'b1;
               cur_ff[h] <= n_ff;
               bef_ff[h] <= 1'b0;
               aft_ff[h] <= 1'b0;
               res_ff.status <= 1'b0;
               res_ff.length_out <= hl + 1'b1;
               state_ff <= S_WR3;
            end
            S_WR3: state_ff <= S_DONE;
            S_FREE_RD: begin
               if (n_ff == NIL || hl == 0) begin
                  if (hused_ff != 0) begin
                     hused_ff <= hused_ff - 1'b1;
                     fhs_ff[HW'(HeadCount - 32'(hused_ff))] <= h;
                     head_ff[h] <= NIL;
                     tail_ff[h] <= NIL;
                     cur_ff[h]  <= NIL;
                     bef_ff[h]  <= 1'b1;
                     aft_ff[h]  <= 1'b0;
                     len_ff[h]  <= '0;
                     live_ff[h] <= 1'b0;
                  end
                  res_ff.status <= 1'b0;
                  res_ff.length_out <= '0;
                  state_ff <= S_DONE;
               end else begin
                  ra_ff <= NW'(n_ff);
                  state_ff <= S_FREE_WT;
               end
            end
            S_FREE_WT: state_ff <= S_FREE_GO;
            S_FREE_GO: begin
               if (nused_ff != 0) begin
                  fs_we_ff <= 1'b1; fs_wa_ff <= top_idx; fs_wd_ff <= NW'(n_ff);
                  nused_ff <= nused_ff - 1'b1;
               end
               n_ff <= nf_rd;
               state_ff <= S_FREE_RD;
            end
            S_DONE: begin
               // hand the result over once the rsp register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // n for insertion: slot 0 of the free stack, read in S_DEC cycle
         if (state_ff == S_RD1 && is_ins) begin
            n_ff <= {1'b0, fs_rd};
         end
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("req accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("rsp beat dropped");
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      (nused_ff <= PW'(NodeCount)) && (32'(hused_ff) <= HeadCount))
      else $error("pool count overflow");
`endif
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the pooled linked list manager: directed and random list operations,
// checked beat by beat against an in-bench model of the lists. Depends on pllm_pkg and the manager.
`default_nettype none
module tb_top;
   localparam int NODES = pllm_pkg::NodeCountDef;
   localparam int HEADS = pllm_pkg::HeadCountDef;
   localparam logic [8:0] NIL = 9'(NODES);
   localparam int CYCLE_LIMIT = 10000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pllm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pllm_pkg::rsp_type rsp_data;

   pooled_linked_list_manager i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- list model ----------------
   logic [31:0] mem_word [NODES];
   logic [8:0]  mem_fwd [NODES];
   logic [8:0]  mem_bwd [NODES];
   logic [8:0]  node_stack [NODES];
   int          node_used;
   logic [3:0]  head_stack [HEADS];
   int          head_used;
   logic [8:0]  lst_head [HEADS];
   logic [8:0]  lst_tail [HEADS];
   logic [8:0]  lst_cur [HEADS];
   logic        lst_bef [HEADS];
   logic        lst_aft [HEADS];
   logic [8:0]  lst_len [HEADS];
   logic        lst_live [HEADS];

   pllm_pkg::rsp_type rsp_pending [$];
   int          errors = 0;
   int          cycles = 0;

   // receiver / sender idling percentages and hold-off
   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   int          rx_hold = 0;

   function automatic logic [31:0] word_of(logic [8:0] n);
      return (n < NIL) ? mem_word[n[7:0]] : 32'd0;
   endfunction
   function automatic logic [8:0] fwd_of(logic [8:0] n);
      return (n < NIL) ? mem_fwd[n[7:0]] : NIL;
   endfunction
   function automatic logic [8:0] bwd_of(logic [8:0] n);
      return (n < NIL) ? mem_bwd[n[7:0]] : NIL;
   endfunction

   task automatic clear_list(int h);
      lst_head[h] = NIL; lst_tail[h] = NIL; lst_cur[h] = NIL;
      lst_bef[h] = 1'b1; lst_aft[h] = 1'b0; lst_len[h] = '0;
   endtask

   task automatic model_reset();
      for (int i = 0; i < NODES; i++) node_stack[i] = 9'(i);
      for (int i = 0; i < HEADS; i++) begin
         head_stack[i] = 4'(i);
         clear_list(i);
         lst_live[i] = 1'b0;
      end
      node_used = 0;
      head_used = 0;
   endtask

   task automatic node_take(output logic [8:0] n);
      if (node_used >= NODES) begin
         n = NIL;
      end else begin
         node_used++;
         n = node_stack[0];
         node_stack[0] = node_stack[NODES - node_used];
      end
   endtask

   task automatic node_give(logic [8:0] n);
      if (node_used == 0 || n >= NIL) return;
      node_stack[NODES - node_used] = n;
      node_used--;
   endtask

   task automatic list_release(int h);
      if (head_used == 0) return;
      head_stack[HEADS - head_used] = 4'(h);
      head_used--;
      clear_list(h);
      lst_live[h] = 1'b0;
   endtask

   task automatic link_in(int h, logic [8:0] p, logic [8:0] q, logic [8:0] n);
      mem_fwd[n[7:0]] = q;
      mem_bwd[n[7:0]] = p;
      if (p == NIL) lst_head[h] = n; else mem_fwd[p[7:0]] = n;
      if (q == NIL) lst_tail[h] = n; else mem_bwd[q[7:0]] = n;
      lst_len[h]++;
   endtask

   task automatic link_out(int h, logic [8:0] n);
      logic [8:0] p, q;
      p = bwd_of(n);
      q = fwd_of(n);
      if (p == NIL) lst_head[h] = q; else mem_fwd[p[7:0]] = q;
      if (q == NIL) lst_tail[h] = p; else mem_bwd[q[7:0]] = p;
      if (lst_len[h] > 0) lst_len[h]--;
      node_give(n);
   endtask

   // Works out the result of one request and updates the model lists.
   task automatic list_op_result(pllm_pkg::req_type rq, output pllm_pkg::rsp_type rs);
      int h, o;
      logic [8:0] cur, n, q;
      logic eff_aft, ok_h;
      pllm_pkg::op_type op;
      h = int'(rq.list_id);
      o = int'(rq.other_list);
      op = pllm_pkg::op_type'(rq.kind);
      rs = '0;
      rs.status = 1'b1;
      ok_h = lst_live[h];
      if (op == pllm_pkg::OP_CREATE) begin
         if (head_used < HEADS) begin
            int nh;
            head_used++;
            nh = int'(head_stack[0]);
            head_stack[0] = head_stack[HEADS - head_used];
            clear_list(nh);
            lst_live[nh] = 1'b1;
            rs.status = 1'b0;
            rs.new_handle = 4'(nh);
         end
      end else if (op != pllm_pkg::OP_NONE && ok_h) begin
         cur = lst_cur[h];
         // lost cursor: null with neither flag counts as past the end
         eff_aft = lst_aft[h] || (cur == NIL && !lst_bef[h]);
         case (op)
            pllm_pkg::OP_COUNT: rs.status = 1'b0;
            pllm_pkg::OP_FIRST, pllm_pkg::OP_LAST: begin
               if (lst_len[h] > 0) begin
                  lst_cur[h] = (op == pllm_pkg::OP_FIRST) ? lst_head[h] : lst_tail[h];
                  lst_bef[h] = 1'b0; lst_aft[h] = 1'b0;
                  rs.item_out = word_of(lst_cur[h]);
                  rs.status = 1'b0;
               end
            end
            pllm_pkg::OP_NEXT: begin
               if (lst_len[h] > 0) begin
                  if (lst_bef[h]) begin
                     lst_cur[h] = lst_head[h];
                     lst_bef[h] = 1'b0;
                     rs.item_out = word_of(lst_cur[h]); rs.status = 1'b0;
                  end else if (cur == lst_tail[h] || eff_aft) begin
                     lst_cur[h] = NIL;
                     lst_aft[h] = 1'b1;
                  end else begin
                     lst_cur[h] = fwd_of(cur);
                     rs.item_out = word_of(lst_cur[h]); rs.status = 1'b0;
                  end
               end
            end
            pllm_pkg::OP_PREV: begin
               if (lst_len[h] > 0) begin
                  if (eff_aft) begin
                     lst_cur[h] = lst_tail[h];
                     lst_aft[h] = 1'b0;
                     rs.item_out = word_of(lst_cur[h]); rs.status = 1'b0;
                  end else if (cur == lst_head[h] || lst_bef[h]) begin
                     lst_cur[h] = NIL;
                     lst_bef[h] = 1'b1;
                  end else begin
                     lst_cur[h] = bwd_of(cur);
                     rs.item_out = word_of(lst_cur[h]); rs.status = 1'b0;
                  end
               end
            end
            pllm_pkg::OP_CURR: begin
               if (lst_len[h] > 0 && cur != NIL) begin
                  rs.item_out = word_of(cur); rs.status = 1'b0;
               end
            end
            pllm_pkg::OP_ADD, pllm_pkg::OP_INSERT,
            pllm_pkg::OP_APPEND, pllm_pkg::OP_PREPEND: begin
               if (rq.item != 0) begin
                  node_take(n);
                  if (n != NIL) begin
                     mem_word[n[7:0]] = rq.item;
                     if (lst_len[h] == 0) begin
                        lst_head[h] = NIL; lst_tail[h] = NIL;
                        link_in(h, NIL, NIL, n);
                     end else if (op == pllm_pkg::OP_PREPEND ||
                                  (op == pllm_pkg::OP_ADD && lst_bef[h]) ||
                                  (op == pllm_pkg::OP_INSERT &&
                                   (lst_bef[h] || cur == lst_head[h]))) begin
                        link_in(h, NIL, lst_head[h], n);
                     end else if (op == pllm_pkg::OP_APPEND || eff_aft ||
                                  (op == pllm_pkg::OP_ADD && cur == lst_tail[h])) begin
                        link_in(h, lst_tail[h], NIL, n);
                     end else if (op == pllm_pkg::OP_ADD) begin
                        link_in(h, cur, fwd_of(cur), n);
                     end else begin
                        link_in(h, bwd_of(cur), cur, n);
                     end
                     lst_cur[h] = n;
                     lst_bef[h] = 1'b0; lst_aft[h] = 1'b0;
                     rs.status = 1'b0;
                  end
               end
            end
            pllm_pkg::OP_REMOVE: begin
               if (cur != NIL && lst_len[h] > 0) begin
                  rs.item_out = word_of(cur);
                  if (cur == lst_tail[h]) begin
                     lst_cur[h] = NIL; lst_aft[h] = 1'b1;
                  end else begin
                     lst_cur[h] = fwd_of(cur);
                  end
                  link_out(h, cur);
                  rs.status = 1'b0;
               end
            end
            pllm_pkg::OP_TRIM: begin
               if (lst_len[h] > 0) begin
                  n = lst_tail[h];
                  rs.item_out = word_of(n);
                  link_out(h, n);
                  if (lst_len[h] == 0) begin
                     lst_head[h] = NIL; lst_tail[h] = NIL; lst_cur[h] = NIL;
                     lst_bef[h] = 1'b1;
                  end else begin
                     lst_cur[h] = lst_tail[h];
                  end
                  rs.status = 1'b0;
               end
            end
            pllm_pkg::OP_CONCAT: begin
               if (lst_live[o] && o != h) begin
                  if (lst_len[o] != 0) begin
                     if (lst_len[h] == 0) begin
                        lst_head[h] = lst_head[o];
                        lst_tail[h] = lst_tail[o];
                        lst_len[h] = lst_len[o];
                     end else begin
                        mem_fwd[lst_tail[h][7:0]] = lst_head[o];
                        mem_bwd[lst_head[o][7:0]] = lst_tail[h];
                        lst_tail[h] = lst_tail[o];
                        lst_len[h] = lst_len[h] + lst_len[o];
                     end
                  end
                  list_release(o);
                  rs.status = 1'b0;
               end
            end
            default: begin
               // free: hand every node back, head to tail
               n = lst_head[h];
               for (int i = 0; i < NODES && n != NIL && lst_len[h] != 0; i++) begin
                  q = fwd_of(n);
                  node_give(n);
                  n = q;
               end
               list_release(h);
               rs.status = 1'b0;
            end
         endcase
         rs.length_out = lst_len[h];
      end
   endtask

   // ---------------- driving ----------------
   task automatic send_beat(pllm_pkg::op_type op, int h, int o, logic [31:0] it);
      pllm_pkg::req_type rq;
      pllm_pkg::rsp_type rs;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      rq.kind = op;
      rq.list_id = 4'(h);
      rq.other_list = 4'(o);
      rq.item = it;
      req_data <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      list_op_result(rq, rs);
      rsp_pending.push_back(rs);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (rsp_pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // receiver: random stall, plus a long hold-off when requested
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            pllm_pkg::rsp_type ex;
            ex = rsp_pending.pop_front();
            if (rsp_data.status !== ex.status) begin
               $error("status exp %0d got %0d", ex.status, rsp_data.status); errors++;
            end
            if (rsp_data.item_out !== ex.item_out) begin
               $error("item_out exp %h got %h", ex.item_out, rsp_data.item_out); errors++;
            end
            if (rsp_data.new_handle !== ex.new_handle) begin
               $error("new_handle exp %0d got %0d", ex.new_handle, rsp_data.new_handle);
               errors++;
            end
            if (rsp_data.length_out !== ex.length_out) begin
               $error("length_out exp %0d got %0d", ex.length_out, rsp_data.length_out);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_item();
      case ($urandom_range(3))
         0: return 32'hFFFF_FFFF;
         1: return 32'(1 << $urandom_range(31));
         default: return $urandom() | 32'd1;
      endcase
   endfunction

   function automatic int live_list();
      int h;
      for (int t = 0; t < 8; t++) begin
         h = int'($urandom_range(HEADS - 1));
         if (lst_live[h]) return h;
      end
      return int'($urandom_range(HEADS - 1));
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      send_beat(pllm_pkg::OP_COUNT, 0, 0, 0);          // handle not live
      send_beat(pllm_pkg::OP_NONE, 0, 0, 0);           // unused kind
      for (int i = 0; i < HEADS; i++) send_beat(pllm_pkg::OP_CREATE, 0, 0, 0);
      send_beat(pllm_pkg::OP_CREATE, 0, 0, 0);         // no free handle
      send_beat(pllm_pkg::OP_APPEND, 0, 0, 0);         // null item
      send_beat(pllm_pkg::OP_FIRST, 0, 0, 0);          // empty list
      send_beat(pllm_pkg::OP_PREV, 0, 0, 0);
      send_beat(pllm_pkg::OP_ADD, 0, 0, 32'hFFFF_FFFF);
      send_beat(pllm_pkg::OP_INSERT, 0, 0, 32'h1);
      send_beat(pllm_pkg::OP_APPEND, 0, 0, 32'h8000_0000);
      send_beat(pllm_pkg::OP_PREPEND, 0, 0, 32'h5555_5555);
      send_beat(pllm_pkg::OP_NEXT, 0, 0, 0);
      send_beat(pllm_pkg::OP_LAST, 0, 0, 0);
      send_beat(pllm_pkg::OP_NEXT, 0, 0, 0);           // off the end
      send_beat(pllm_pkg::OP_CURR, 0, 0, 0);           // null cursor
      send_beat(pllm_pkg::OP_REMOVE, 0, 0, 0);
      send_beat(pllm_pkg::OP_PREV, 0, 0, 0);
      send_beat(pllm_pkg::OP_REMOVE, 0, 0, 0);         // tail removal
      send_beat(pllm_pkg::OP_TRIM, 0, 0, 0);
      send_beat(pllm_pkg::OP_APPEND, 1, 0, 32'hAAAA_AAAA);
      send_beat(pllm_pkg::OP_CONCAT, 0, 0, 0);         // with itself
      send_beat(pllm_pkg::OP_CONCAT, 0, 1, 0);
      send_beat(pllm_pkg::OP_FREE, 0, 0, 0);
      for (int i = 0; i < HEADS; i++) send_beat(pllm_pkg::OP_FREE, i, 0, 0);
      wait_drained();
   endtask

   task automatic test_pool_full();
      int h;
      send_beat(pllm_pkg::OP_CREATE, 0, 0, 0);
      h = int'(rsp_pending[$].new_handle);
      for (int i = 0; i <= NODES; i++) send_beat(pllm_pkg::OP_APPEND, h, 0, rand_item());
      send_beat(pllm_pkg::OP_FREE, h, 0, 0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      pllm_pkg::op_type op;
      int r;
      for (int i = 0; i < count; i++) begin
         r = int'($urandom_range(99));
         if (r < 6) op = pllm_pkg::OP_CREATE;
         else if (r < 9) op = pllm_pkg::OP_FREE;
         else if (r < 12) op = pllm_pkg::OP_CONCAT;
         else if (r < 14) op = pllm_pkg::OP_NONE;
         else if (r < 50) op = pllm_pkg::op_type'($urandom_range(pllm_pkg::OP_ADD,
                                                                pllm_pkg::OP_PREPEND));
         else op = pllm_pkg::op_type'($urandom_range(pllm_pkg::OP_COUNT, pllm_pkg::OP_TRIM));
         send_beat(op, live_list(), live_list(),
                   ($urandom_range(19) == 0) ? 32'd0 : rand_item());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      rx_hold = 300;
      for (int i = 0; i < 40; i++) send_beat(pllm_pkg::OP_COUNT, live_list(), 0, 0);
      wait_drained();
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_full();
      test_random(175);
      tx_idle_pct = 83;
      test_random(175);
      tx_idle_pct = 0; rx_stall_pct = 83;
      test_random(175);
      tx_idle_pct = 22; rx_stall_pct = 22;
      test_random(175);
      tx_idle_pct = 0; rx_stall_pct = 0;
      test_backpressure();
      repeat (50) @(posedge clock);
      if (errors == 0 && rsp_pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
hdl/pllm_pkg.sv
hdl/pllm_ram.sv
hdl/pooled_linked_list_manager.sv
dv/tb_top.sv
